// ===== sv/icl_pkg.sv =====
// Package with shared types, codes and widths for the idle-count load monitor.
package icl_pkg;

   // Fractional bits of the load format and the full-scale load value.
   localparam int LOAD_FRAC_BITS = 8;
   localparam int FULL_SCALE     = 100 << LOAD_FRAC_BITS;
   localparam int LOAD_W         = 15;
   localparam int DEFAULT_CORES  = 2;

   // Tally, peak and divider widths.
   localparam int TALLY_W   = 32;
   localparam int DIV_DEN_W = 32;
   localparam int DIV_Q_W   = LOAD_W;
   localparam int DIV_NUM_W = DIV_DEN_W + DIV_Q_W;
   localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

   // Smoothing weight format and products.
   localparam int EMA_W     = 7;
   localparam int PROD_W    = EMA_W + LOAD_W;
   localparam int SAMPLES_W = 16;
   localparam logic [EMA_W-1:0] EMA_MAX   = EMA_W'(100);
   localparam logic [EMA_W-1:0] EMA_RESET = EMA_W'(50);
   localparam logic [SAMPLES_W-1:0] WARMUP_RESET = SAMPLES_W'(10);

   // Channel widths.
   localparam int REQ_DATA_W = 8;
   localparam int RSP_FIELD_W = 3 + 3 * LOAD_W + 1 + 2 * TALLY_W;
   localparam int RSP_DATA_W = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_FIELD_W;
   localparam int CSR_DATA_W = SAMPLES_W;
   localparam int CSR_IDX_W  = 1;

   // Request command codes.
   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_SAMPLE = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;
   localparam logic [1:0] CMD_NOP    = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_EMA_PERCENT    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WARMUP_SAMPLES = 1'd1;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_RAW_START,
      ST_RAW_DIV,
      ST_EMA_MUL,
      ST_EMA_START,
      ST_EMA_DIV,
      ST_STORE,
      ST_AVG_START,
      ST_AVG_DIV,
      ST_EMIT
   } icl_state_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic sample_go;
      logic div_done;
      logic raw_zero;
      logic first_sample;
      logic last_core;
      logic out_free;
   } icl_stat_type;

   // Controls from the sequencer to the datapath.
   typedef struct packed {
      logic req_ready;
      logic load_core;
      logic raw_start;
      logic raw_take;
      logic ema_mul;
      logic ema_start;
      logic ema_take;
      logic store_core;
      logic avg_start;
      logic avg_take;
      logic emit;
   } icl_ctl_type;

endpackage

// ===== sv/icl_div.sv =====
// Shared restoring divider that produces one quotient bit per cycle.
module icl_div
   import icl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] numer,
   input  logic [DIV_DEN_W-1:0] denom,
   output logic                 done,
   output logic [DIV_Q_W-1:0]   quotient
);

   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_Q_W-1:0]   q_ff, q_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   trial;
   logic                 ge;

   // One step: try to subtract the divisor from the partial remainder.
   // The low register holds the numerator bits still to come and collects
   // quotient bits from the bottom; the quotient must fit in DIV_Q_W bits.
   always_comb begin
      trial    = {rem_ff, q_ff[DIV_Q_W-1]} - {1'b0, den_ff};
      ge       = ~trial[DIV_DEN_W];
      rem_in   = rem_ff;
      den_in   = den_ff;
      q_in     = q_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = numer[DIV_NUM_W-1:DIV_Q_W];
         q_in     = numer[DIV_Q_W-1:0];
         den_in   = denom;
         count_in = DIV_CNT_W'(DIV_Q_W);
      end else if (count_ff != '0) begin
         rem_in   = ge ? trial[DIV_DEN_W-1:0] : {rem_ff[DIV_DEN_W-2:0], q_ff[DIV_Q_W-1]};
         q_in     = {q_ff[DIV_Q_W-2:0], ge};
         count_in = count_ff - 1'b1;
         done_in  = (count_ff == DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// ===== sv/icl_ctrl.sv =====
// Sequencer that steps a sample through the shared divider core by core.
module icl_ctrl
   import icl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  icl_stat_type stat,
   output icl_ctl_type  ctl
);

   icl_state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (stat.sample_go) state_in = ST_LOAD;
         ST_LOAD:      state_in = ST_RAW_START;
         ST_RAW_START: state_in = stat.raw_zero ? ST_EMA_MUL : ST_RAW_DIV;
         ST_RAW_DIV:   if (stat.div_done) state_in = ST_EMA_MUL;
         ST_EMA_MUL:   state_in = stat.first_sample ? ST_STORE : ST_EMA_START;
         ST_EMA_START: state_in = ST_EMA_DIV;
         ST_EMA_DIV:   if (stat.div_done) state_in = ST_STORE;
         ST_STORE:     state_in = stat.last_core ? ST_AVG_START : ST_LOAD;
         ST_AVG_START: state_in = ST_AVG_DIV;
         ST_AVG_DIV:   if (stat.div_done) state_in = ST_EMIT;
         ST_EMIT:      if (stat.out_free && stat.last_core) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Controls for the datapath.
   always_comb begin
      ctl = '0;
      case (state_ff)
         ST_IDLE:      ctl.req_ready  = 1'b1;
         ST_LOAD:      ctl.load_core  = 1'b1;
         ST_RAW_START: ctl.raw_start  = 1'b1;
         ST_RAW_DIV:   ctl.raw_take   = stat.div_done;
         ST_EMA_MUL:   ctl.ema_mul    = 1'b1;
         ST_EMA_START: ctl.ema_start  = 1'b1;
         ST_EMA_DIV:   ctl.ema_take   = stat.div_done;
         ST_STORE:     ctl.store_core = 1'b1;
         ST_AVG_START: ctl.avg_start  = 1'b1;
         ST_AVG_DIV:   ctl.avg_take   = stat.div_done;
         ST_EMIT:      ctl.emit       = stat.out_free;
         default:      ctl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/idle_count_load_monitor_unit.sv =====
// Top level of the per-core load monitor built on idle-tick counting.
// Idle tick, clear and no-op requests are taken back to back.
// A sample request runs each core through two divisions in the shared
// divider (fewer for a zero raw load or the first sample), then the
// average division, then loads one result per core;
// requests are not taken until the last result is loaded.
// Synchronous active-high reset clears the state and restores the registers, but not the working or payload registers.
module idle_count_load_monitor_unit
   import icl_pkg::*;
#(
   parameter int CORES = DEFAULT_CORES
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // cmd, core_select
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // core_index, raw_load, smooth_load, average_load, is_ready,
   // idle_observed, idle_peak_out
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CNT_W = (CORES > 1) ? $clog2(CORES) : 1;
   localparam int SUM_W = LOAD_W + $clog2(CORES + 1);

   icl_stat_type stat;
   icl_ctl_type  ctl;

   logic [1:0] req_cmd;
   logic [2:0] req_sel;
   logic       accept;
   logic       sel_ok;
   logic [CNT_W-1:0] tally_addr;

   // Configuration registers.
   logic [EMA_W-1:0]     ema_ff, ema_in;
   logic [SAMPLES_W-1:0] warmup_ff, warmup_in;

   // Per-core state.
   logic [TALLY_W-1:0] tally_ff [CORES];
   logic [TALLY_W-1:0] tally_in [CORES];
   logic [TALLY_W-1:0] peak_ff [CORES];
   logic [TALLY_W-1:0] peak_in [CORES];
   logic [TALLY_W-1:0] obs_ff [CORES];
   logic [TALLY_W-1:0] obs_in [CORES];
   logic [LOAD_W-1:0]  raw_store_ff [CORES];
   logic [LOAD_W-1:0]  raw_store_in [CORES];
   logic [LOAD_W-1:0]  smooth_store_ff [CORES];
   logic [LOAD_W-1:0]  smooth_store_in [CORES];

   // Global state.
   logic [LOAD_W-1:0]    avg_ff, avg_in;
   logic [SAMPLES_W-1:0] samples_ff, samples_in, samples_nx;
   logic                 ready_ff, ready_in;

   // Working registers of the sequence.
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [TALLY_W-1:0] diff_ff, diff_in;
   logic [TALLY_W-1:0] cur_peak_ff, cur_peak_in;
   logic               zero_ff, zero_in;
   logic [LOAD_W-1:0]  raw_ff, raw_in;
   logic [LOAD_W-1:0]  smooth_ff, smooth_in;
   logic [PROD_W-1:0]  prod_a_ff, prod_a_in;
   logic [PROD_W-1:0]  prod_b_ff, prod_b_in;
   logic [EMA_W-1:0]   ema_sat;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         out_core_ff, out_core_in;
   logic [LOAD_W-1:0]  out_raw_ff, out_raw_in;
   logic [LOAD_W-1:0]  out_smooth_ff, out_smooth_in;
   logic [LOAD_W-1:0]  out_avg_ff, out_avg_in;
   logic               out_ready_ff, out_ready_in;
   logic [TALLY_W-1:0] out_idle_ff, out_idle_in;
   logic [TALLY_W-1:0] out_peak_ff, out_peak_in;
   logic               out_last_ff, out_last_in;

   // Divider operands.
   logic                 div_start;
   logic [DIV_NUM_W-1:0] div_numer;
   logic [DIV_DEN_W-1:0] div_denom;
   logic                 div_done;
   logic [DIV_Q_W-1:0]   div_quot;

   assign req_cmd    = req_tdata[1:0];
   assign req_sel    = req_tdata[4:2];
   assign req_tready = ctl.req_ready;
   assign accept     = req_tvalid & ctl.req_ready;
   assign sel_ok     = (32'(req_sel) < 32'(CORES));
   assign tally_addr = ctl.req_ready ? CNT_W'(req_sel) : cnt_ff;
   assign ema_sat    = (ema_ff > EMA_MAX) ? EMA_MAX : ema_ff;
   assign samples_nx = (samples_ff == '1) ? samples_ff : samples_ff + 1'b1;

   // Status for the sequencer.
   assign stat.sample_go    = accept && (req_cmd == CMD_SAMPLE);
   assign stat.div_done     = div_done;
   assign stat.raw_zero     = zero_ff;
   assign stat.first_sample = (samples_ff == '0);
   assign stat.last_core    = (32'(cnt_ff) == 32'(CORES - 1));
   assign stat.out_free     = ~rsp_valid_ff | rsp_tready;

   icl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctl   (ctl)
   );

   // Operand selection for the shared divider.
   always_comb begin
      div_start = 1'b0;
      div_numer = '0;
      div_denom = '0;
      if (ctl.raw_start) begin
         div_start = ~zero_ff;
         div_numer = DIV_NUM_W'(diff_ff) * DIV_NUM_W'(FULL_SCALE)
                   + DIV_NUM_W'(cur_peak_ff >> 1);
         div_denom = cur_peak_ff;
      end else if (ctl.ema_start) begin
         div_start = 1'b1;
         div_numer = DIV_NUM_W'(prod_a_ff) + DIV_NUM_W'(prod_b_ff) + DIV_NUM_W'(50);
         div_denom = DIV_DEN_W'(100);
      end else if (ctl.avg_start) begin
         div_start = 1'b1;
         div_numer = DIV_NUM_W'(sum_ff) + DIV_NUM_W'(CORES / 2);
         div_denom = DIV_DEN_W'(CORES);
      end
   end

   icl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_numer),
      .denom    (div_denom),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Next values of the state and working registers.
   always_comb begin
      ema_in          = ema_ff;
      warmup_in       = warmup_ff;
      tally_in        = tally_ff;
      peak_in         = peak_ff;
      obs_in          = obs_ff;
      raw_store_in    = raw_store_ff;
      smooth_store_in = smooth_store_ff;
      avg_in          = avg_ff;
      samples_in      = samples_ff;
      ready_in        = ready_ff;
      cnt_in          = cnt_ff;
      sum_in          = sum_ff;
      diff_in         = diff_ff;
      cur_peak_in     = cur_peak_ff;
      zero_in         = zero_ff;
      raw_in          = raw_ff;
      smooth_in       = smooth_ff;
      prod_a_in       = prod_a_ff;
      prod_b_in       = prod_b_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_tready;
      out_core_in     = out_core_ff;
      out_raw_in      = out_raw_ff;
      out_smooth_in   = out_smooth_ff;
      out_avg_in      = out_avg_ff;
      out_ready_in    = out_ready_ff;
      out_idle_in     = out_idle_ff;
      out_peak_in     = out_peak_ff;
      out_last_in     = out_last_ff;

      // Configuration writes.
      if (csr_we) begin
         case (csr_index)
            CSR_EMA_PERCENT:    ema_in    = csr_wdata[EMA_W-1:0];
            CSR_WARMUP_SAMPLES: warmup_in = csr_wdata[SAMPLES_W-1:0];
            default:            ;
         endcase
      end

      // Requests taken while idle.
      if (accept) begin
         case (req_cmd)
            CMD_TICK: begin
               if (sel_ok && (tally_ff[tally_addr] != '1)) begin
                  tally_in[tally_addr] = tally_ff[tally_addr] + 1'b1;
               end
            end
            CMD_SAMPLE: begin
               cnt_in = '0;
               sum_in = '0;
            end
            CMD_CLEAR: begin
               for (int c = 0; c < CORES; c++) begin
                  tally_in[c]        = '0;
                  peak_in[c]         = '0;
                  raw_store_in[c]    = '0;
                  smooth_store_in[c] = '0;
               end
               avg_in     = '0;
               samples_in = '0;
               ready_in   = 1'b0;
            end
            default: ;
         endcase
      end

      // Take the tally and raise the peak. The raw load is zero exactly when
      // the new tally is not below the old peak.
      if (ctl.load_core) begin
         tally_in[tally_addr] = '0;
         obs_in[cnt_ff]       = tally_ff[cnt_ff];
         zero_in              = (tally_ff[cnt_ff] >= peak_ff[cnt_ff]);
         diff_in              = peak_ff[cnt_ff] - tally_ff[cnt_ff];
         cur_peak_in          = zero_in ? tally_ff[cnt_ff] : peak_ff[cnt_ff];
         peak_in[cnt_ff]      = cur_peak_in;
      end

      if (ctl.raw_start && zero_ff) begin
         raw_in = '0;
      end
      if (ctl.raw_take) begin
         raw_in = div_quot;
      end

      // Moving average products, or the raw load on the first sample.
      if (ctl.ema_mul) begin
         if (samples_ff == '0) begin
            smooth_in = raw_ff;
         end else begin
            prod_a_in = PROD_W'(ema_sat) * PROD_W'(raw_ff);
            prod_b_in = PROD_W'(EMA_MAX - ema_sat) * PROD_W'(smooth_store_ff[cnt_ff]);
         end
      end
      if (ctl.ema_take) begin
         smooth_in = div_quot;
      end

      // Commit this core and move on.
      if (ctl.store_core) begin
         raw_store_in[cnt_ff]    = raw_ff;
         smooth_store_in[cnt_ff] = smooth_ff;
         sum_in                  = sum_ff + SUM_W'(smooth_ff);
         if (!stat.last_core) begin
            cnt_in = cnt_ff + 1'b1;
         end
      end

      // Average over cores, sample count and warm-up flag.
      if (ctl.avg_take) begin
         avg_in     = div_quot;
         samples_in = samples_nx;
         ready_in   = ready_ff | (samples_nx >= warmup_ff);
         cnt_in     = '0;
      end

      // Load one result per core into the output register.
      if (ctl.emit) begin
         rsp_valid_in  = 1'b1;
         out_core_in   = 3'(cnt_ff);
         out_raw_in    = raw_store_ff[cnt_ff];
         out_smooth_in = smooth_store_ff[cnt_ff];
         out_avg_in    = avg_ff;
         out_ready_in  = ready_ff;
         out_idle_in   = obs_ff[cnt_ff];
         out_peak_in   = peak_ff[cnt_ff];
         out_last_in   = stat.last_core;
         if (!stat.last_core) begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ema_ff       <= EMA_RESET;
         warmup_ff    <= WARMUP_RESET;
         for (int c = 0; c < CORES; c++) begin
            tally_ff[c]        <= '0;
            peak_ff[c]         <= '0;
            raw_store_ff[c]    <= '0;
            smooth_store_ff[c] <= '0;
         end
         avg_ff       <= '0;
         samples_ff   <= '0;
         ready_ff     <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ema_ff          <= ema_in;
         warmup_ff       <= warmup_in;
         tally_ff        <= tally_in;
         peak_ff         <= peak_in;
         raw_store_ff    <= raw_store_in;
         smooth_store_ff <= smooth_store_in;
         avg_ff          <= avg_in;
         samples_ff      <= samples_in;
         ready_ff        <= ready_in;
         cnt_ff          <= cnt_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      obs_ff        <= obs_in;
      sum_ff        <= sum_in;
      diff_ff       <= diff_in;
      cur_peak_ff   <= cur_peak_in;
      zero_ff       <= zero_in;
      raw_ff        <= raw_in;
      smooth_ff     <= smooth_in;
      prod_a_ff     <= prod_a_in;
      prod_b_ff     <= prod_b_in;
      out_core_ff   <= out_core_in;
      out_raw_ff    <= out_raw_in;
      out_smooth_ff <= out_smooth_in;
      out_avg_ff    <= out_avg_in;
      out_ready_ff  <= out_ready_in;
      out_idle_ff   <= out_idle_in;
      out_peak_ff   <= out_peak_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, out_peak_ff, out_idle_ff, out_ready_ff,
                        out_avg_ff, out_smooth_ff, out_raw_ff, out_core_ff};

endmodule

// ===== sv/icl_checker.sv =====
// Port-level checker for the load monitor, bound to the top level.
module icl_checker
   import icl_pkg::*;
#(
   parameter int CORES = DEFAULT_CORES
)
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // A taken sample request makes the block busy in the next cycle.
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tdata[1:0] == CMD_SAMPLE) |=> !req_tready)
      else $error("block ready right after a sample request");

   // While results of a sample remain, no request is taken.
   a_busy_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request taken while results remain");

   // The last result of a sample describes the highest core.
   a_last_core: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> (32'(rsp_tdata[2:0]) == 32'(CORES - 1)))
      else $error("last result not for the highest core");

   // Raw and smooth loads never exceed full scale.
   a_full_scale: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_tdata[17:3]) <= 32'(FULL_SCALE))
                  && (32'(rsp_tdata[32:18]) <= 32'(FULL_SCALE)))
      else $error("load above full scale");

endmodule

bind idle_count_load_monitor_unit icl_checker #(.CORES(CORES)) u_icl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ===== verif/icl_load_checker.sv =====
// Checker that tracks the load monitor's state and compares every load report it emits.
`timescale 1ns / 100ps
module icl_load_checker
   import icl_pkg::*;
#(
   parameter int CORES = DEFAULT_CORES
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // cmd, core_select
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // core_index, raw_load, smooth_load, average_load, is_ready,
   // idle_observed, idle_peak_out
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    reports_pending
);

   localparam int SHOWN_LIMIT = 10;

   // One per-core load report as it leaves the block.
   typedef struct packed {
      logic [2:0]         core_index;
      logic [LOAD_W-1:0]  raw_pct;
      logic [LOAD_W-1:0]  smooth_pct;
      logic [LOAD_W-1:0]  average_load;
      logic               is_ready;
      logic [TALLY_W-1:0] idle_observed;
      logic [TALLY_W-1:0] idle_peak;
      logic               last_core;
   } load_report_type;

   // Shadow copy of the registers and the per-core load state.
   logic [EMA_W-1:0]     weight_pct;
   logic [SAMPLES_W-1:0] warmup_target;
   logic [TALLY_W-1:0]   idle_tally [CORES];
   logic [TALLY_W-1:0]   idle_peak  [CORES];
   logic [LOAD_W-1:0]    smooth_now [CORES];
   logic [SAMPLES_W-1:0] samples_done;
   logic                 ready_seen;
   load_report_type      expected_reports [$];

   // Return all load state to zero; the registers keep their values.
   task automatic wipe_load_state();
      for (int c = 0; c < CORES; c++) begin
         idle_tally[c] = '0;
         idle_peak[c]  = '0;
         smooth_now[c] = '0;
      end
      samples_done = '0;
      ready_seen   = 1'b0;
   endtask

   // Close one sampling interval and queue one report per core.
   task automatic take_sample();
      logic [TALLY_W-1:0] observed [CORES];
      logic [LOAD_W-1:0]  raw_now [CORES];
      logic [63:0]        weight, raw, blend, total, mean;
      load_report_type    rep;
      weight = (weight_pct > EMA_MAX) ? 64'(EMA_MAX) : 64'(weight_pct);
      total  = '0;
      for (int c = 0; c < CORES; c++) begin
         observed[c]   = idle_tally[c];
         idle_tally[c] = '0;
         if (observed[c] > idle_peak[c]) begin
            idle_peak[c] = observed[c];
         end
         // Load is the share of the peak idle count that went unused.
         if (idle_peak[c] == '0 || observed[c] >= idle_peak[c]) begin
            raw = '0;
         end else begin
            raw = (64'(FULL_SCALE) * 64'(idle_peak[c] - observed[c])
                   + 64'(idle_peak[c] >> 1)) / 64'(idle_peak[c]);
            if (raw > 64'(FULL_SCALE)) begin
               raw = 64'(FULL_SCALE);
            end
         end
         // The first sample after reset or clear seeds the average directly.
         if (samples_done == '0) begin
            blend = raw;
         end else begin
            blend = (weight * raw + (64'd100 - weight) * 64'(smooth_now[c])
                     + 64'd50) / 64'd100;
         end
         raw_now[c]    = raw[LOAD_W-1:0];
         smooth_now[c] = blend[LOAD_W-1:0];
         total         = total + 64'(smooth_now[c]);
      end
      mean = (total + 64'(CORES / 2)) / 64'(CORES);
      if (samples_done != '1) begin
         samples_done = samples_done + 1'b1;
      end
      if (samples_done >= warmup_target) begin
         ready_seen = 1'b1;
      end
      for (int c = 0; c < CORES; c++) begin
         rep.core_index    = 3'(c);
         rep.raw_pct       = raw_now[c];
         rep.smooth_pct    = smooth_now[c];
         rep.average_load  = mean[LOAD_W-1:0];
         rep.is_ready      = ready_seen;
         rep.idle_observed = observed[c];
         rep.idle_peak     = idle_peak[c];
         rep.last_core     = (c == CORES - 1);
         expected_reports.push_back(rep);
      end
   endtask

   // Track register writes and requests, then check the report taken this cycle.
   always @(posedge clock) begin : track_and_check
      int unsigned     sel;
      load_report_type got;
      load_report_type want;
      if (reset) begin
         weight_pct    = EMA_RESET;
         warmup_target = WARMUP_RESET;
         wipe_load_state();
         expected_reports.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_EMA_PERCENT) begin
               weight_pct = csr_wdata[EMA_W-1:0];
            end else if (csr_index == CSR_WARMUP_SAMPLES) begin
               warmup_target = csr_wdata[SAMPLES_W-1:0];
            end
         end

         if (req_tvalid && req_tready) begin
            sel = 32'(req_tdata[4:2]);
            case (req_tdata[1:0])
               CMD_TICK: begin
                  // Ticks for cores that do not exist are dropped; tallies saturate.
                  if (sel < CORES && idle_tally[sel] != '1) begin
                     idle_tally[sel] = idle_tally[sel] + 1'b1;
                  end
               end
               CMD_SAMPLE: begin
                  take_sample();
               end
               CMD_CLEAR: begin
                  wipe_load_state();
               end
               default: begin
               end
            endcase
         end

         if (rsp_tvalid && rsp_tready) begin
            got.core_index    = rsp_tdata[2:0];
            got.raw_pct       = rsp_tdata[3 +: LOAD_W];
            got.smooth_pct    = rsp_tdata[3 + LOAD_W +: LOAD_W];
            got.average_load  = rsp_tdata[3 + 2 * LOAD_W +: LOAD_W];
            got.is_ready      = rsp_tdata[3 + 3 * LOAD_W];
            got.idle_observed = rsp_tdata[4 + 3 * LOAD_W +: TALLY_W];
            got.idle_peak     = rsp_tdata[4 + 3 * LOAD_W + TALLY_W +: TALLY_W];
            got.last_core     = rsp_tlast;
            if (expected_reports.size() == 0) begin
               if (fail_count < SHOWN_LIMIT) begin
                  $display("%0t: load report with none outstanding: core %0d raw %0d",
                           $realtime, got.core_index, got.raw_pct);
               end
               fail_count++;
            end else begin
               want = expected_reports.pop_front();
               if (got !== want) begin
                  if (fail_count < SHOWN_LIMIT) begin
                     $display("%0t: load report mismatch", $realtime);
                     $write("  expected core %0d raw %0d smooth %0d avg %0d",
                            want.core_index, want.raw_pct, want.smooth_pct,
                            want.average_load);
                     $display(" ready %0b idle %0d peak %0d last %0b",
                              want.is_ready, want.idle_observed,
                              want.idle_peak, want.last_core);
                     $write("  actual   core %0d raw %0d smooth %0d avg %0d",
                            got.core_index, got.raw_pct, got.smooth_pct,
                            got.average_load);
                     $display(" ready %0b idle %0d peak %0d last %0b",
                              got.is_ready, got.idle_observed,
                              got.idle_peak, got.last_core);
                  end
                  fail_count++;
               end
            end
         end
      end
      reports_pending = expected_reports.size();
   end

endmodule

// ===== verif/tb_idle_count_load_monitor_unit.sv =====
// Testbench top for the idle-count load monitor: request stimulus, result sink and verdict.
`timescale 1ns / 100ps
module tb_idle_count_load_monitor_unit;
   import icl_pkg::*;

   localparam int CORES         = DEFAULT_CORES;
   localparam int STALL_LIMIT   = 5000;
   localparam int HOLD_CYCLES   = 600;
   localparam int SETTLE_CYCLES = 150;
   localparam int TICK_SETTLE   = 20;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    reports_pending;
   logic                  quiet_tail = 1'b0;
   logic                  hold_kick = 1'b0;
   int                    stall_cycles = 0;

   idle_count_load_monitor_unit #(.CORES(CORES)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   icl_load_checker #(.CORES(CORES)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .reports_pending (reports_pending)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort when neither channel has moved a request or a report for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Report sink: random back-pressure bursts, one long hold on request, none at the tail.
   initial begin : report_sink
      logic seen_kick;
      rsp_tready = 1'b0;
      seen_kick  = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_kick != seen_kick) begin
            seen_kick = hold_kick;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(negedge clock);
         end
      end
   end

   // Offer one request, with an occasional gap ahead of it, and wait for it to be taken.
   task automatic send_req(input logic [1:0] cmd, input logic [2:0] core);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, core, cmd};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Stop offering requests until every report is in, then let the block settle.
   task automatic drain_results(input int extra);
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (reports_pending != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   // Mostly idle-tick intervals closed by a sample, with clears, no-ops,
   // stray ticks and back-to-back samples mixed in.
   task automatic run_traffic(input int budget);
      int         counted;
      int         ticks;
      int         bias;
      int         pick;
      logic [2:0] core;
      counted = 0;
      while (counted < budget) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            send_req(CMD_CLEAR, 3'($urandom_range(0, 7)));
            counted++;
         end else if (pick == 1) begin
            send_req(CMD_NOP, 3'($urandom_range(0, 7)));
         end else if (pick == 2) begin
            send_req(CMD_TICK, 3'($urandom_range(CORES, 7)));
         end else if (pick == 3) begin
            send_req(CMD_SAMPLE, 3'($urandom_range(0, 7)));
            counted++;
         end else begin
            ticks = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 60) : $urandom_range(0, 16);
            bias  = $urandom_range(0, 100);
            repeat (ticks) begin
               core = ($urandom_range(0, 99) < bias) ? 3'd0 : 3'(CORES - 1);
               send_req(CMD_TICK, core);
            end
            send_req(CMD_SAMPLE, 3'($urandom_range(0, 7)));
            counted += ticks + 1;
         end
      end
   endtask

   initial begin : stimulus
      int ema_plan [5];
      int warmup_plan [5];
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      ema_plan    = '{0, 100, 127, 0, 1};
      warmup_plan = '{0, 65535, 1, 0, 3};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part with the reset register values. First sample seeds
      // the average; ticks for absent cores and no-ops change nothing.
      send_req(CMD_TICK, 3'd0);
      send_req(CMD_TICK, 3'd0);
      send_req(CMD_TICK, 3'd0);
      send_req(CMD_TICK, 3'd1);
      send_req(CMD_TICK, 3'd7);
      send_req(CMD_TICK, 3'd4);
      send_req(CMD_NOP, 3'd5);
      send_req(CMD_SAMPLE, 3'd0);
      // Fewer ticks than the peak, then an interval with no ticks at all.
      send_req(CMD_TICK, 3'd0);
      send_req(CMD_SAMPLE, 3'd2);
      send_req(CMD_SAMPLE, 3'd7);
      // Clear, then a sample with zero peaks.
      send_req(CMD_CLEAR, 3'd7);
      send_req(CMD_SAMPLE, 3'd0);
      send_req(CMD_TICK, 3'd1);
      send_req(CMD_TICK, 3'd1);
      send_req(CMD_TICK, 3'd0);
      send_req(CMD_SAMPLE, 3'd1);
      // A new, higher peak on one core.
      send_req(CMD_TICK, 3'd1);
      send_req(CMD_TICK, 3'd1);
      send_req(CMD_TICK, 3'd1);
      send_req(CMD_TICK, 3'd1);
      send_req(CMD_SAMPLE, 3'd3);
      run_traffic(16);

      // Register settings, extremes first; each change happens with the block idle.
      for (int p = 0; p < 5; p++) begin
         drain_results(TICK_SETTLE);
         if (p == 3) begin
            ema_plan[p]    = $urandom_range(0, 100);
            warmup_plan[p] = $urandom_range(2, 6);
         end
         write_csr(CSR_EMA_PERCENT, CSR_DATA_W'(ema_plan[p]));
         write_csr(CSR_WARMUP_SAMPLES, CSR_DATA_W'(warmup_plan[p]));
         csr_we <= 1'b0;
         // Long report hold so the block backs up and stalls its requests.
         if (p == 1) begin
            hold_kick <= ~hold_kick;
         end
         if (p == 4) begin
            quiet_tail <= 1'b1;
         end
         run_traffic(22);
      end

      drain_results(SETTLE_CYCLES);
      if (fail_count == 0 && reports_pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
